@@ hdl/dem_pkg.sv @@
// Shared constants and types for the DE mutation block.
// No dependencies; imported by every module of the block.
package dem_pkg;

    localparam int DATA_W     = 32;  // donor and result element width
    localparam int SCALE_BITS = 14;  // fraction bits of the scale factor
    localparam int F_W        = 15;  // scale factor register width
    localparam int MULT_W     = 16;  // multiplier bound width
    localparam int SEC_W      = 20;  // start-time bound width
    localparam int STEP_W     = 16;  // time step width
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // Divider pipeline: seven lanes share one divisor per word.
    localparam int LANES          = 7;
    localparam int BITS_PER_STAGE = 4;
    localparam int DIV_STAGES     = DATA_W / BITS_PER_STAGE;
    localparam int DONORS         = 5;

    // Lane order
    localparam int LN_BASE   = 0;
    localparam int LN_PLUS   = 1;
    localparam int LN_MINUS  = 2;
    localparam int LN_PLUS2  = 3;
    localparam int LN_MINUS2 = 4;
    localparam int LN_UP     = 5;
    localparam int LN_LO     = 6;

    // Working width of the sum and the repaired value
    localparam int SW = 56;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_MULT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_MULT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_START = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_START = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEP      = 3'd5;

    typedef struct packed {
        logic [DONORS-1:0] neg;   // donor was negative, quotient gets its sign back
        logic              pair;  // second difference enabled
        logic              start; // start-time element
    } dem_side_t;

    typedef struct packed {
        logic [DATA_W-1:0] num;
        logic [STEP_W-1:0] rem;
    } dem_div_t;

endpackage

@@ hdl/dem_div_pipe.sv @@
// Pipelined unsigned restoring divider, several lanes sharing one divisor.
// Four quotient bits per stage. Depends on dem_pkg.
module dem_div_pipe
    import dem_pkg::*;
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_vld,
    input  logic [LANES-1:0][DATA_W-1:0]      in_num,
    input  logic [STEP_W-1:0]                 in_den,
    input  dem_side_t                         in_side,
    output logic                              out_vld,
    output logic [LANES-1:0][DATA_W-1:0]      out_num,
    output dem_side_t                         out_side
);

    function automatic dem_div_t div_steps(input logic [DATA_W-1:0] num,
                                           input logic [STEP_W-1:0] rem,
                                           input logic [STEP_W-1:0] den);
        logic [STEP_W:0]   r;
        logic [DATA_W-1:0] n;
        dem_div_t          res;
        n = num;
        r = {1'b0, rem};
        for (int i = 0; i < BITS_PER_STAGE; i++)
        begin
            r = {r[STEP_W-1:0], n[DATA_W-1]};
            n = {n[DATA_W-2:0], 1'b0};
            if (r >= {1'b0, den})
            begin
                r    = r - {1'b0, den};
                n[0] = 1'b1;
            end
        end
        res.num = n;
        res.rem = r[STEP_W-1:0];
        return res;
    endfunction

    logic [DIV_STAGES-1:0]               vld_reg;
    logic [LANES-1:0][DATA_W-1:0]        num_reg  [DIV_STAGES];
    logic [LANES-1:0][STEP_W-1:0]        rem_reg  [DIV_STAGES];
    logic [STEP_W-1:0]                   den_reg  [DIV_STAGES];
    dem_side_t                           side_reg [DIV_STAGES];

    logic [LANES-1:0][DATA_W-1:0]        src_num  [DIV_STAGES];
    logic [LANES-1:0][STEP_W-1:0]        src_rem  [DIV_STAGES];
    logic [STEP_W-1:0]                   src_den  [DIV_STAGES];
    dem_side_t                           src_side [DIV_STAGES];
    logic [DIV_STAGES-1:0]               src_vld;

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_stage
        if (g == 0)
        begin : g_first
            assign src_num[g]  = in_num;
            assign src_rem[g]  = '0;
            assign src_den[g]  = in_den;
            assign src_side[g] = in_side;
            assign src_vld[g]  = in_vld;
        end
        else
        begin : g_rest
            assign src_num[g]  = num_reg[g-1];
            assign src_rem[g]  = rem_reg[g-1];
            assign src_den[g]  = den_reg[g-1];
            assign src_side[g] = side_reg[g-1];
            assign src_vld[g]  = vld_reg[g-1];
        end

        logic [LANES-1:0][DATA_W-1:0] num_next;
        logic [LANES-1:0][STEP_W-1:0] rem_next;

        always_comb
        begin
            dem_div_t r;
            for (int l = 0; l < LANES; l++)
            begin
                r           = div_steps(src_num[g][l], src_rem[g][l], src_den[g]);
                num_next[l] = r.num;
                rem_next[l] = r.rem;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[g] <= 1'b0;
            else if (en)
                vld_reg[g] <= src_vld[g];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_reg[g]  <= num_next;
                rem_reg[g]  <= rem_next;
                den_reg[g]  <= src_den[g];
                side_reg[g] <= src_side[g];
            end
        end
    end

    assign out_vld  = vld_reg[DIV_STAGES-1];
    assign out_num  = num_reg[DIV_STAGES-1];
    assign out_side = side_reg[DIV_STAGES-1];

endmodule

@@ hdl/dem_mut_core.sv @@
// Mutation arithmetic: differences, scaling, sum, bound repair, rescale.
// Five register stages after the divider. Depends on dem_pkg.
module dem_mut_core
    import dem_pkg::*;
#(
    parameter int FRACTION_BITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_vld,
    input  logic [LANES-1:0][DATA_W-1:0]  in_num,
    input  dem_side_t                     in_side,
    input  logic [F_W-1:0]                scale_factor,
    input  logic [MULT_W-1:0]             max_multiplier,
    input  logic [MULT_W-1:0]             min_multiplier,
    input  logic [STEP_W-1:0]             step_eff,
    output logic                          out_vld,
    output logic signed [SW-1:0]          out_res,
    output logic                          out_repaired,
    output logic                          out_last
);

    localparam logic signed [SW-1:0] HALF = SW'(64'sd1 <<< (SCALE_BITS - 1));

    // stage 1: signed quotients and differences
    logic signed [DATA_W:0]   q [DONORS];
    logic [4:0]               vld_reg;
    logic signed [DATA_W:0]   qb1_reg;
    logic signed [DATA_W+1:0] d1_reg, d2_reg;
    logic [SEC_W-1:0]         up1_reg, lo1_reg;
    logic                     st1_reg;

    always_comb
    begin
        for (int i = 0; i < DONORS; i++)
        begin
            q[i] = in_side.neg[i] ? -$signed({1'b0, in_num[i]}) : $signed({1'b0, in_num[i]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[3:0], in_vld};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qb1_reg <= q[LN_BASE];
            d1_reg  <= (DATA_W+2)'(q[LN_PLUS]) - (DATA_W+2)'(q[LN_MINUS]);
            d2_reg  <= in_side.pair ?
                       (DATA_W+2)'(q[LN_PLUS2]) - (DATA_W+2)'(q[LN_MINUS2]) : '0;
            up1_reg <= in_num[LN_UP][SEC_W-1:0];
            lo1_reg <= in_num[LN_LO][SEC_W-1:0];
            st1_reg <= in_side.start;
        end
    end

    // stage 2: scaled differences
    localparam int PW = DATA_W + 2 + F_W + 1;
    logic signed [PW-1:0]   p1_reg, p2_reg;
    logic signed [PW-1:0]   prod1, prod2;
    logic signed [DATA_W:0] qb2_reg;
    logic [SEC_W-1:0]       up2_reg, lo2_reg;
    logic                   st2_reg;
    logic signed [F_W:0]    f_s;

    assign f_s   = $signed({1'b0, scale_factor});
    assign prod1 = f_s * d1_reg;
    assign prod2 = f_s * d2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg  <= prod1;
            p2_reg  <= prod2;
            qb2_reg <= qb1_reg;
            up2_reg <= up1_reg;
            lo2_reg <= lo1_reg;
            st2_reg <= st1_reg;
        end
    end

    // stage 3: sum and rounding of the multiplier value
    logic signed [SW-1:0]   s_sum;
    logic signed [SW-1:0]   s3_reg, t3_reg;
    logic signed [DATA_W:0] qb3_reg;
    logic [SEC_W-1:0]       up3_reg, lo3_reg;
    logic                   st3_reg;

    assign s_sum = (SW'(qb2_reg) <<< SCALE_BITS) + SW'(p1_reg) + SW'(p2_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_reg  <= s_sum;
            t3_reg  <= (s_sum + HALF) >>> SCALE_BITS;
            qb3_reg <= qb2_reg;
            up3_reg <= up2_reg;
            lo3_reg <= lo2_reg;
            st3_reg <= st2_reg;
        end
    end

    // stage 4: bound repair
    logic signed [SW-1:0] qb_w, up_m, lo_m, up_s, lo_s, s_fix, res_next;
    logic                 rep_next;
    logic signed [SW-1:0] res4_reg;
    logic                 rep4_reg, st4_reg;

    assign qb_w = SW'(qb3_reg);
    assign up_m = $signed(SW'({max_multiplier, {FRACTION_BITS{1'b0}}}));
    assign lo_m = $signed(SW'({min_multiplier, {FRACTION_BITS{1'b0}}}));
    assign up_s = $signed(SW'(up3_reg));
    assign lo_s = $signed(SW'(lo3_reg));

    always_comb
    begin
        rep_next = 1'b0;
        s_fix    = s3_reg;
        res_next = t3_reg;
        if (st3_reg)
        begin
            priority if (s3_reg > (up_s <<< SCALE_BITS))
            begin
                s_fix    = (qb_w + up_s) <<< (SCALE_BITS - 1);
                rep_next = 1'b1;
            end
            else if (s3_reg < (lo_s <<< SCALE_BITS))
            begin
                s_fix    = (qb_w + lo_s) <<< (SCALE_BITS - 1);
                rep_next = 1'b1;
            end
            res_next = (s_fix + HALF) >>> SCALE_BITS;
        end
        else
        begin
            priority if (t3_reg > up_m)
            begin
                res_next = (qb_w + up_m) >>> 1;
                rep_next = 1'b1;
            end
            else if (t3_reg < lo_m)
            begin
                res_next = (qb_w + lo_m) >>> 1;
                rep_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res4_reg <= res_next;
            rep4_reg <= rep_next;
            st4_reg  <= st3_reg;
        end
    end

    // stage 5: step count back to seconds
    localparam int NW = 40;
    logic signed [NW-1:0]     n_s;
    logic signed [STEP_W:0]   step_s;
    logic signed [SW-1:0]     sec_s;
    logic signed [SW-1:0]     res5_reg;
    logic                     rep5_reg, st5_reg;

    assign n_s    = res4_reg[NW-1:0];
    assign step_s = $signed({1'b0, step_eff});
    assign sec_s  = n_s * step_s;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res5_reg <= st4_reg ? sec_s : res4_reg;
            rep5_reg <= rep4_reg;
            st5_reg  <= st4_reg;
        end
    end

    assign out_vld      = vld_reg[4];
    assign out_res      = res5_reg;
    assign out_repaired = rep5_reg;
    assign out_last     = st5_reg;

endmodule

@@ hdl/de_mutation_with_bound_repair.sv @@
// Top level of the DE rand/1 and rand/2 mutation with bound repair.
// Uses dem_pkg, dem_div_pipe and dem_mut_core.
//
//  channel   | direction | handshake             | payload
//  ----------+-----------+-----------------------+------------------------------
//  s_*       | in        | s_tvalid / s_tready   | five donors, pair flag, marker
//  m_*       | out       | m_tvalid / m_tready   | trial value, repair flag, last
//  cfg_*     | in        | cfg_wen, no wait      | register index and write data
//
// One word per cycle unless m_tready stalls the output. Path: input register, eight
// divider stages (four quotient bits each), five arithmetic stages, output
// register. The divider depth sets the latency.
// rst_n clears valid bits and loads register defaults; data registers are
// not reset. A stall on m_tready freezes the whole pipeline in place; s_tready
// is high whenever the output register is empty or being taken.
module de_mutation_with_bound_repair
    import dem_pkg::*;
#(
    parameter int FRACTION_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [5*DATA_W-1:0]   s_tdata,   // base, plus, minus, plus_two, minus_two
    input  logic [0:0]            s_tuser,   // use_second_pair
    input  logic                  s_tlast,   // is_start_time
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [DATA_W-1:0]     m_tdata,   // trial_value
    output logic [0:0]            m_tuser,   // was_repaired
    output logic                  m_tlast,   // last_element
    input  logic                  cfg_wen,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // configuration registers
    logic [F_W-1:0]    scale_reg;
    logic [MULT_W-1:0] max_mult_reg, min_mult_reg;
    logic [SEC_W-1:0]  max_start_reg, min_start_reg;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg     <= F_W'(8192);
            max_mult_reg  <= MULT_W'(65535);
            min_mult_reg  <= '0;
            max_start_reg <= SEC_W'(1048575);
            min_start_reg <= '0;
            step_reg      <= STEP_W'(3600);
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                REG_SCALE:     scale_reg     <= cfg_wdata[F_W-1:0];
                REG_MAX_MULT:  max_mult_reg  <= cfg_wdata[MULT_W-1:0];
                REG_MIN_MULT:  min_mult_reg  <= cfg_wdata[MULT_W-1:0];
                REG_MAX_START: max_start_reg <= cfg_wdata[SEC_W-1:0];
                REG_MIN_START: min_start_reg <= cfg_wdata[SEC_W-1:0];
                REG_STEP:      step_reg      <= cfg_wdata[STEP_W-1:0];
                default:       ;
            endcase
        end
    end

    // a zero step behaves as one
    assign step_eff = (step_reg == '0) ? STEP_W'(1) : step_reg;

    // global advance: everything moves unless a finished word is held
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // input register
    logic                          in_vld_reg;
    logic [DONORS-1:0][DATA_W-1:0] don_reg;
    logic                          pair_reg, start_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (en)
            in_vld_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            don_reg   <= s_tdata;
            pair_reg  <= s_tuser[0];
            start_reg <= s_tlast;
        end
    end

    // magnitudes into the divider; multipliers divide by one and pass unchanged
    logic [LANES-1:0][DATA_W-1:0] div_num;
    logic [STEP_W-1:0]            div_den;
    dem_side_t                    div_side;

    always_comb
    begin
        for (int i = 0; i < DONORS; i++)
        begin
            div_side.neg[i] = don_reg[i][DATA_W-1];
            div_num[i]      = don_reg[i][DATA_W-1] ? (~don_reg[i] + DATA_W'(1)) : don_reg[i];
        end
        div_num[LN_UP] = DATA_W'(max_start_reg);
        div_num[LN_LO] = DATA_W'(min_start_reg);
        div_side.pair  = pair_reg;
        div_side.start = start_reg;
        div_den        = start_reg ? step_eff : STEP_W'(1);
    end

    logic                         q_vld;
    logic [LANES-1:0][DATA_W-1:0] q_num;
    dem_side_t                    q_side;

    dem_div_pipe u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (in_vld_reg),
        .in_num   (div_num),
        .in_den   (div_den),
        .in_side  (div_side),
        .out_vld  (q_vld),
        .out_num  (q_num),
        .out_side (q_side)
    );

    logic                 c_vld, c_rep, c_last;
    logic signed [SW-1:0] c_res;

    dem_mut_core #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .in_vld         (q_vld),
        .in_num         (q_num),
        .in_side        (q_side),
        .scale_factor   (scale_reg),
        .max_multiplier (max_mult_reg),
        .min_multiplier (min_mult_reg),
        .step_eff       (step_eff),
        .out_vld        (c_vld),
        .out_res        (c_res),
        .out_repaired   (c_rep),
        .out_last       (c_last)
    );

    // saturate to 32 bits into the output register
    localparam logic signed [SW-1:0] SAT_MAX = SW'(64'sd2147483647);
    localparam logic signed [SW-1:0] SAT_MIN = SW'(-64'sd2147483648);

    logic [DATA_W-1:0] sat_next;
    logic              out_vld_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic              out_rep_reg, out_last_reg;

    always_comb
    begin
        priority if (c_res > SAT_MAX)
            sat_next = SAT_MAX[DATA_W-1:0];
        else if (c_res < SAT_MIN)
            sat_next = SAT_MIN[DATA_W-1:0];
        else
            sat_next = c_res[DATA_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= c_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= sat_next;
            out_rep_reg  <= c_rep;
            out_last_reg <= c_last;
        end
    end

    assign m_tvalid   = out_vld_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_rep_reg;
    assign m_tlast    = out_last_reg;

endmodule

@@ hdl/dem_checker.sv @@
// Port-level assertions for de_mutation_with_bound_repair, and their bind.
// Depends on dem_pkg.
module dem_port_checks
    import dem_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [DATA_W-1:0] m_tdata,
    input logic [0:0]        m_tuser,
    input logic              m_tlast
);

    // input side opens exactly when the output word is free or leaving
    a_ready_follows_out: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow output state");

    // a held word keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled output word changed");

    // nothing comes out right after reset
    a_no_out_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("output valid right after reset");

endmodule

bind de_mutation_with_bound_repair dem_port_checks u_dem_port_checks (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
